[hdl/glide_source_voice_selector_unit_defines.svh]
// glide source voice selector: assertion macros
// used by the checker module; needs clk and arst_n in the using scope
`ifndef GLIDE_SOURCE_VOICE_SELECTOR_UNIT_DEFINES_SVH
`define GLIDE_SOURCE_VOICE_SELECTOR_UNIT_DEFINES_SVH

// same-cycle implication, reset masked
`define GSVS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("gsvs check failed");

// next-cycle implication, reset masked
`define GSVS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("gsvs check failed");

`endif

[hdl/gsvs_pkg.sv]
// glide source voice selector: shared types and constants
// no dependencies
package gsvs_pkg;

	typedef enum logic [2:0] {
		FUNC_HELD   = 3'd0,
		FUNC_REL    = 3'd1,
		FUNC_STATUS = 3'd2,
		FUNC_CLEAR  = 3'd3,
		FUNC_QUERY  = 3'd4
	} func_t;

	typedef enum logic [1:0] {
		ST_IDLE      = 2'd0,
		ST_PLAYING   = 2'd1,
		ST_RELEASING = 2'd2,
		ST_STEAL     = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		CFG_ENABLE_L0 = 3'd0,
		CFG_ENABLE_L1 = 3'd1,
		CFG_RANGE_L0  = 3'd2,
		CFG_RANGE_L1  = 3'd3,
		CFG_MODE_L0   = 3'd4,
		CFG_MODE_L1   = 3'd5,
		CFG_WINDOW_L0 = 3'd6,
		CFG_WINDOW_L1 = 3'd7
	} cfg_idx_t;

	typedef enum logic [2:0] {
		BS_IDLE,
		BS_OP_RD,
		BS_OP_WR,
		BS_SCAN,
		BS_SCAN_END,
		BS_RESULT
	} bstate_t;

	localparam int Q_DEPTH = 2;
	localparam logic [6:0] RANGE_RST = 7'd12;
	localparam logic [23:0] WINDOW_RST = 24'd4800;

	// command with the layer's settings already resolved
	typedef struct packed {
		func_t       func;
		logic [3:0]  voice_index;
		logic [6:0]  note_number;
		logic        layer;
		status_t     voice_status;
		logic        stop_fading;
		logic        gliding;
		logic [14:0] glide_pitch;
		logic [31:0] sample_time;
		logic        enable;
		logic [14:0] limit;
		logic        mode;
		logic [23:0] window;
	} cmd_t;

	typedef struct packed {
		logic        mark_valid;
		logic        released;
		logic [6:0]  note;
		logic        layer;
		logic [31:0] order;
		logic [31:0] stamp;
		status_t     status;
		logic        stop;
		logic        glide;
		logic [14:0] pitch;
	} voice_t;

	typedef struct packed {
		logic empty;
		logic full;
	} q_stat_t;

endpackage

[hdl/gsvs_if.sv]
// glide source voice selector: request, result and config channels
// depends on nothing
interface gsvs_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  func;
	logic [3:0]  voice_index;
	logic [6:0]  note_number;
	logic        layer;
	logic [1:0]  voice_status;
	logic        stop_fading;
	logic        gliding;
	logic [14:0] glide_pitch;
	logic [31:0] sample_time;

	modport source (output valid, func, voice_index, note_number, layer, voice_status,
		stop_fading, gliding, glide_pitch, sample_time, input ready);
	modport sink (input valid, func, voice_index, note_number, layer, voice_status,
		stop_fading, gliding, glide_pitch, sample_time, output ready);
endinterface

interface gsvs_res_if;
	logic        valid;
	logic        ready;
	logic        found;
	logic [3:0]  source_voice;
	logic [14:0] source_pitch;
	logic [14:0] distance;

	modport source (output valid, found, source_voice, source_pitch, distance, input ready);
	modport sink (input valid, found, source_voice, source_pitch, distance, output ready);
endinterface

interface gsvs_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [23:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

[hdl/glide_source_voice_selector_unit.sv]
// glide source voice selector top level: front, command queue, back
// mark, status and clear requests occupy the back for its read and write states; a query for its scan and result states
// the scan reads one voice a cycle through the single read port of the voice table
// a two-entry queue lets requests be accepted while the back scans or a result waits
// arst_n clears config to defaults, table valid bits, order counter and all handshakes
module glide_source_voice_selector_unit import gsvs_pkg::*; #(
	parameter int NUM_VOICES = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	gsvs_req_if.sink   req,
	gsvs_res_if.source res,
	gsvs_cfg_if.sink   cfg
);

	q_stat_t q_stat;
	logic    push;
	cmd_t    push_cmd;
	logic    pop;
	cmd_t    head;

	gsvs_front #(
		.NUM_VOICES(NUM_VOICES)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.cfg      (cfg),
		.q_stat   (q_stat),
		.push     (push),
		.push_cmd (push_cmd)
	);

	gsvs_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.q_stat   (q_stat)
	);

	gsvs_back #(
		.NUM_VOICES(NUM_VOICES)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.q_stat (q_stat),
		.pop    (pop),
		.res    (res)
	);

endmodule

[hdl/gsvs_front.sv]
// glide source voice selector: request intake, config registers, classification
// depends on gsvs_pkg and gsvs_if
module gsvs_front import gsvs_pkg::*; #(
	parameter int NUM_VOICES = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	gsvs_req_if.sink  req,
	gsvs_cfg_if.sink  cfg,
	input  q_stat_t   q_stat,
	output logic      push,
	output cmd_t      push_cmd
);

	logic [1:0]  enable_q;
	logic [6:0]  range_q [2];
	logic [1:0]  mode_q;
	logic [23:0] window_q [2];
	logic        idx_ok;
	logic        keep;
	logic [23:0] win;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q    <= '0;
			range_q[0]  <= RANGE_RST;
			range_q[1]  <= RANGE_RST;
			mode_q      <= '0;
			window_q[0] <= WINDOW_RST;
			window_q[1] <= WINDOW_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_ENABLE_L0: enable_q[0] <= cfg.data[0];
				CFG_ENABLE_L1: enable_q[1] <= cfg.data[0];
				CFG_RANGE_L0:  range_q[0]  <= cfg.data[6:0];
				CFG_RANGE_L1:  range_q[1]  <= cfg.data[6:0];
				CFG_MODE_L0:   mode_q[0]   <= cfg.data[0];
				CFG_MODE_L1:   mode_q[1]   <= cfg.data[0];
				CFG_WINDOW_L0: window_q[0] <= cfg.data;
				CFG_WINDOW_L1: window_q[1] <= cfg.data;
				default: ;
			endcase
		end
	end

	assign req.ready = !q_stat.full;
	assign idx_ok = ({3'b000, req.voice_index} < 7'(NUM_VOICES));

	always_comb begin
		if (req.func inside {FUNC_HELD, FUNC_REL, FUNC_STATUS, FUNC_CLEAR}) begin
			keep = idx_ok;
		end else begin
			keep = (req.func == FUNC_QUERY);
		end
	end

	assign push = req.valid && req.ready && keep;

	// zero window counts as one sample
	assign win = (window_q[req.layer] == '0) ? 24'd1 : window_q[req.layer];

	always_comb begin
		push_cmd.func         = func_t'(req.func);
		push_cmd.voice_index  = req.voice_index;
		push_cmd.note_number  = req.note_number;
		push_cmd.layer        = req.layer;
		push_cmd.voice_status = status_t'(req.voice_status);
		push_cmd.stop_fading  = req.stop_fading;
		push_cmd.gliding      = req.gliding;
		push_cmd.glide_pitch  = req.glide_pitch;
		push_cmd.sample_time  = req.sample_time;
		push_cmd.enable       = enable_q[req.layer];
		push_cmd.limit        = {range_q[req.layer], 8'd0};
		push_cmd.mode         = mode_q[req.layer];
		push_cmd.window       = win;
	end

endmodule

[hdl/gsvs_queue.sv]
// glide source voice selector: short command queue between front and back
// depends on gsvs_pkg
module gsvs_queue import gsvs_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  cmd_t    push_cmd,
	input  logic    pop,
	output cmd_t    head,
	output q_stat_t q_stat
);

	localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int CW = $clog2(Q_DEPTH + 1);

	cmd_t            mem_q [Q_DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_push;
	logic            do_pop;

	assign q_stat.empty = (count_q == '0);
	assign q_stat.full  = (count_q == CW'(Q_DEPTH));
	assign do_push = push && !q_stat.full;
	assign do_pop  = pop && !q_stat.empty;
	assign head = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: ;
			endcase
		end
	end

endmodule

[hdl/gsvs_back.sv]
// glide source voice selector: voice table, mark updates and source scan
// depends on gsvs_pkg and gsvs_if
module gsvs_back import gsvs_pkg::*; #(
	parameter int NUM_VOICES = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  cmd_t       head,
	input  q_stat_t    q_stat,
	output logic       pop,
	gsvs_res_if.source res
);

	localparam int VW = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
	localparam logic [VW-1:0] LAST = VW'(NUM_VOICES - 1);

	bstate_t state_q, state_d;

	voice_t          mem [NUM_VOICES];
	logic [NUM_VOICES-1:0] written_q;
	voice_t          rd_q;
	logic            rd_vld_q;
	voice_t          entry;
	logic [VW-1:0]   rd_addr;
	logic [VW-1:0]   wr_addr;
	logic            wr_en;
	voice_t          wr_data;
	logic            new_mark;
	logic            rel;
	logic            same;

	cmd_t            cmd_q;
	logic [VW-1:0]   cnt_q;
	logic            issue;
	logic            ev_s1;
	logic [VW-1:0]   ev_idx_s1;
	logic [31:0]     order_cnt_q;

	logic            have_q;
	logic [VW-1:0]   best_idx_q;
	logic [14:0]     best_d_q;
	logic [31:0]     lead_order_q;
	logic [14:0]     best_p_q;

	logic [14:0]     p;
	logic [14:0]     tgt;
	logic [14:0]     d;
	logic [31:0]     age;
	logic            eligible;
	logic            better;
	logic            take;
	logic            load;

	logic            res_vld_q;
	logic            res_found_q;
	logic [3:0]      res_voice_q;
	logic [14:0]     res_pitch_q;
	logic [14:0]     res_dist_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			BS_IDLE: begin
				if (!q_stat.empty) begin
					state_d = (head.func == FUNC_QUERY) ? BS_SCAN : BS_OP_RD;
				end
			end
			BS_OP_RD:    state_d = BS_OP_WR;
			BS_OP_WR:    state_d = BS_IDLE;
			BS_SCAN: begin
				if (cnt_q == LAST) begin
					state_d = BS_SCAN_END;
				end
			end
			BS_SCAN_END: state_d = BS_RESULT;
			BS_RESULT: begin
				if (!res_vld_q || res.ready) begin
					state_d = BS_IDLE;
				end
			end
			default:     state_d = BS_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		pop   = 1'b0;
		issue = 1'b0;
		wr_en = 1'b0;
		load  = 1'b0;
		case (state_q)
			BS_IDLE:   pop   = !q_stat.empty;
			BS_OP_WR:  wr_en = 1'b1;
			BS_SCAN:   issue = 1'b1;
			BS_RESULT: load  = !res_vld_q || res.ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// voice table
	assign rd_addr = (state_q == BS_OP_RD) ? VW'(cmd_q.voice_index) : cnt_q;
	assign wr_addr = VW'(cmd_q.voice_index);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
			rd_vld_q  <= 1'b0;
		end else begin
			if (wr_en) begin
				written_q[wr_addr] <= 1'b1;
			end
			rd_vld_q <= written_q[rd_addr];
		end
	end

	assign entry = rd_vld_q ? rd_q : '0;

	// read-modify-write of one entry
	assign rel  = (cmd_q.func == FUNC_REL);
	assign same = entry.mark_valid && (entry.released == rel) &&
		(entry.note == cmd_q.note_number) && (entry.layer == cmd_q.layer);

	always_comb begin
		wr_data  = entry;
		new_mark = 1'b0;
		case (cmd_q.func)
			FUNC_HELD, FUNC_REL: begin
				if (!same) begin
					new_mark           = 1'b1;
					wr_data.mark_valid = 1'b1;
					wr_data.released   = rel;
					wr_data.note       = cmd_q.note_number;
					wr_data.layer      = cmd_q.layer;
					wr_data.order      = order_cnt_q + 32'd1;
					wr_data.stamp      = rel ? cmd_q.sample_time : '0;
				end
			end
			FUNC_STATUS: begin
				wr_data.status = cmd_q.voice_status;
				wr_data.stop   = cmd_q.stop_fading;
				wr_data.glide  = cmd_q.gliding;
				wr_data.pitch  = cmd_q.glide_pitch;
			end
			FUNC_CLEAR: begin
				wr_data.mark_valid = 1'b0;
				wr_data.released   = 1'b0;
				wr_data.note       = '0;
				wr_data.layer      = 1'b0;
				wr_data.order      = '0;
				wr_data.stamp      = '0;
				wr_data.glide      = 1'b0;
				wr_data.pitch      = '0;
			end
			default: ;
		endcase
	end

	// candidate check for the entry read last cycle
	always_comb begin
		p   = entry.glide ? entry.pitch : {entry.note, 8'd0};
		tgt = {cmd_q.note_number, 8'd0};
		d   = (p >= tgt) ? (p - tgt) : (tgt - p);
		age = cmd_q.sample_time - entry.stamp;
		eligible = cmd_q.enable && entry.mark_valid &&
			(entry.status != ST_IDLE) && (entry.status != ST_STEAL) &&
			!entry.stop && (entry.layer == cmd_q.layer) && (d <= cmd_q.limit) &&
			(entry.released ?
				((entry.status == ST_RELEASING) && (age <= {8'd0, cmd_q.window})) :
				(entry.status == ST_PLAYING));
		if (!have_q) begin
			better = 1'b1;
		end else if (cmd_q.mode) begin
			better = (entry.order > lead_order_q) ||
				((entry.order == lead_order_q) && (d < best_d_q));
		end else begin
			better = (d < best_d_q) || ((d == best_d_q) && (entry.order > lead_order_q));
		end
		take = ev_s1 && eligible && better;
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q <= head;
		end
		ev_idx_s1 <= cnt_q;
		if (take) begin
			best_idx_q   <= ev_idx_s1;
			best_d_q     <= d;
			lead_order_q <= entry.order;
			best_p_q     <= p;
		end
		if (load) begin
			res_found_q <= have_q;
			res_voice_q <= have_q ? 4'(best_idx_q) : '0;
			res_pitch_q <= have_q ? best_p_q : '0;
			res_dist_q  <= have_q ? best_d_q : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			ev_s1       <= 1'b0;
			have_q      <= 1'b0;
			order_cnt_q <= '0;
			res_vld_q   <= 1'b0;
		end else begin
			ev_s1 <= issue;
			if (pop) begin
				cnt_q  <= '0;
				have_q <= 1'b0;
			end else if (issue) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (take) begin
				have_q <= 1'b1;
			end
			if (wr_en && new_mark) begin
				order_cnt_q <= order_cnt_q + 32'd1;
			end
			if (load) begin
				res_vld_q <= 1'b1;
			end else if (res.ready) begin
				res_vld_q <= 1'b0;
			end
		end
	end

	assign res.valid        = res_vld_q;
	assign res.found        = res_found_q;
	assign res.source_voice = res_voice_q;
	assign res.source_pitch = res_pitch_q;
	assign res.distance     = res_dist_q;

endmodule

[hdl/gsvs_checker.sv]
// glide source voice selector: port-level checks, bound to the top level
// depends on glide_source_voice_selector_unit_defines.svh
`include "glide_source_voice_selector_unit_defines.svh"

module gsvs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        res_valid,
	input logic        res_ready,
	input logic        res_found,
	input logic [3:0]  res_source_voice,
	input logic [14:0] res_source_pitch,
	input logic [14:0] res_distance
);

	// miss carries all-zero fields
	`GSVS_ASSERT_NOW(a_miss_zero, res_valid && !res_found,
		(res_source_voice == 4'd0) && (res_source_pitch == 15'd0) && (res_distance == 15'd0))

	// distance never exceeds the widest range
	`GSVS_ASSERT_NOW(a_dist_bound, res_valid && res_found, res_distance <= 15'd32512)

	`GSVS_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid)

	`GSVS_ASSERT_NEXT(a_res_stable, res_valid && !res_ready,
		$stable(res_found) && $stable(res_source_voice) && $stable(res_source_pitch) &&
		$stable(res_distance))

endmodule

bind glide_source_voice_selector_unit gsvs_checker u_gsvs_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.res_valid        (res.valid),
	.res_ready        (res.ready),
	.res_found        (res.found),
	.res_source_voice (res.source_voice),
	.res_source_pitch (res.source_pitch),
	.res_distance     (res.distance)
);

[tb/gsvs_source_check.sv]
// glide source voice selector: watches the request, result and config channels
// keeps its own voice table and settings, predicts each query and compares the result
// depends on gsvs_pkg and gsvs_if
`timescale 1ns / 1ps

module gsvs_source_check import gsvs_pkg::*; #(
	parameter int NUM_VOICES = 16
) (
	input  logic clk,
	input  logic arst_n,
	gsvs_req_if  req,
	gsvs_res_if  res,
	gsvs_cfg_if  cfg,
	output int   fail_count,
	output int   outstanding
);

	typedef struct packed {
		logic        found;
		logic [3:0]  voice;
		logic [14:0] pitch;
		logic [14:0] gap;
	} pick_t;

	pick_t       pick_q[$];
	pick_t       want;
	voice_t      vtab[NUM_VOICES];
	logic        layer_en[2];
	logic [6:0]  layer_range[2];
	logic        layer_mode[2];
	logic [23:0] layer_win[2];
	logic [31:0] stamp_count;
	int          fails = 0;

	task automatic report_mismatch(string what, int got, int exp_val);
		fails++;
		if (fails <= 100)
			$display("gsvs check: %s got %0d want %0d at %0t", what, got, exp_val, $realtime);
	endtask

	task automatic clear_model();
		for (int i = 0; i < NUM_VOICES; i++)
			vtab[i] = '0;
		for (int l = 0; l < 2; l++) begin
			layer_en[l] = 1'b0;
			layer_range[l] = RANGE_RST;
			layer_mode[l] = 1'b0;
			layer_win[l] = WINDOW_RST;
		end
		stamp_count = '0;
		pick_q.delete();
	endtask

	// a mark that already says the same thing keeps its stamp
	function automatic void stamp_mark(int i, logic rel, logic [6:0] n, logic l, logic [31:0] t);
		if (vtab[i].mark_valid && vtab[i].released == rel && vtab[i].note == n &&
			vtab[i].layer == l)
			return;
		vtab[i].mark_valid = 1'b1;
		vtab[i].released = rel;
		vtab[i].note = n;
		vtab[i].layer = l;
		stamp_count = stamp_count + 32'd1;
		vtab[i].order = stamp_count;
		vtab[i].stamp = rel ? t : 32'd0;
	endfunction

	function automatic pick_t find_source(logic [6:0] n, logic l, logic [31:0] t);
		pick_t       best;
		logic        have;
		logic        take;
		logic [31:0] lead_order;
		logic [31:0] age;
		logic [31:0] win;
		logic [14:0] p;
		logic [14:0] d;
		logic [14:0] target;
		logic [14:0] lim;
		best = '0;
		have = 1'b0;
		lead_order = '0;
		target = {n, 8'h00};
		lim = {layer_range[l], 8'h00};
		win = (layer_win[l] == 24'd0) ? 32'd1 : {8'h00, layer_win[l]};
		if (layer_en[l]) begin
			for (int i = 0; i < NUM_VOICES; i++) begin
				if (!vtab[i].mark_valid || vtab[i].status == ST_IDLE || vtab[i].status == ST_STEAL)
					continue;
				if (vtab[i].stop || vtab[i].layer != l)
					continue;
				p = vtab[i].glide ? vtab[i].pitch : {vtab[i].note, 8'h00};
				d = (p >= target) ? p - target : target - p;
				if (d > lim)
					continue;
				if (!vtab[i].released) begin
					if (vtab[i].status != ST_PLAYING)
						continue;
				end else begin
					age = t - vtab[i].stamp;
					if (vtab[i].status != ST_RELEASING || age > win)
						continue;
				end
				if (!have)
					take = 1'b1;
				else if (layer_mode[l])
					take = vtab[i].order > lead_order ||
						(vtab[i].order == lead_order && d < best.gap);
				else
					take = d < best.gap || (d == best.gap && vtab[i].order > lead_order);
				if (take) begin
					have = 1'b1;
					best.found = 1'b1;
					best.voice = 4'(i);
					best.pitch = p;
					best.gap = d;
					lead_order = vtab[i].order;
				end
			end
		end
		return best;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_model();
		end else begin
			if (res.valid && res.ready) begin
				if (pick_q.size() == 0) begin
					report_mismatch("result with no query waiting", 1, 0);
				end else begin
					want = pick_q.pop_front();
					if (res.found !== want.found)
						report_mismatch("found", res.found, want.found);
					if (res.source_voice !== want.voice)
						report_mismatch("source_voice", res.source_voice, want.voice);
					if (res.source_pitch !== want.pitch)
						report_mismatch("source_pitch", res.source_pitch, want.pitch);
					if (res.distance !== want.gap)
						report_mismatch("distance", res.distance, want.gap);
				end
			end
			if (cfg.valid && cfg.ready) begin
				case (cfg_idx_t'(cfg.index))
					CFG_ENABLE_L0: layer_en[0] = cfg.data[0];
					CFG_ENABLE_L1: layer_en[1] = cfg.data[0];
					CFG_RANGE_L0:  layer_range[0] = cfg.data[6:0];
					CFG_RANGE_L1:  layer_range[1] = cfg.data[6:0];
					CFG_MODE_L0:   layer_mode[0] = cfg.data[0];
					CFG_MODE_L1:   layer_mode[1] = cfg.data[0];
					CFG_WINDOW_L0: layer_win[0] = cfg.data;
					CFG_WINDOW_L1: layer_win[1] = cfg.data;
					default: ;
				endcase
			end
			if (req.valid && req.ready) begin
				case (req.func)
					FUNC_HELD: begin
						if (int'(req.voice_index) < NUM_VOICES)
							stamp_mark(int'(req.voice_index), 1'b0, req.note_number, req.layer,
								req.sample_time);
					end
					FUNC_REL: begin
						if (int'(req.voice_index) < NUM_VOICES)
							stamp_mark(int'(req.voice_index), 1'b1, req.note_number, req.layer,
								req.sample_time);
					end
					FUNC_STATUS: begin
						if (int'(req.voice_index) < NUM_VOICES) begin
							vtab[req.voice_index].status = status_t'(req.voice_status);
							vtab[req.voice_index].stop = req.stop_fading;
							vtab[req.voice_index].glide = req.gliding;
							vtab[req.voice_index].pitch = req.glide_pitch;
						end
					end
					FUNC_CLEAR: begin
						// status and stop fade survive a clear
						if (int'(req.voice_index) < NUM_VOICES) begin
							vtab[req.voice_index].mark_valid = 1'b0;
							vtab[req.voice_index].released = 1'b0;
							vtab[req.voice_index].note = '0;
							vtab[req.voice_index].layer = 1'b0;
							vtab[req.voice_index].order = '0;
							vtab[req.voice_index].stamp = '0;
							vtab[req.voice_index].glide = 1'b0;
							vtab[req.voice_index].pitch = '0;
						end
					end
					FUNC_QUERY: pick_q.push_back(find_source(req.note_number, req.layer,
						req.sample_time));
					default: ;
				endcase
			end
		end
		fail_count <= fails;
		outstanding <= pick_q.size();
	end

endmodule

[tb/tb_glide_source_voice_selector_unit.sv]
// glide source voice selector testbench top: clock, reset, stimulus and verdict
// drives directed then random requests over several settings; gsvs_source_check predicts
// depends on gsvs_pkg, gsvs_if, gsvs_source_check and the block
`timescale 1ns / 1ps

module tb_glide_source_voice_selector_unit;
	import gsvs_pkg::*;

	localparam int NUM_VOICES   = 16;
	localparam int DRAIN_CYCLES = 4 * (NUM_VOICES + 4);
	localparam int QUIET_LIMIT  = 5000;
	localparam int PHASE_COUNT  = 8;
	localparam int PHASE_ITEMS  = 125;
	localparam int HOLD_CYCLES  = 400;

	typedef struct packed {
		logic [2:0]  func;
		logic [3:0]  voice;
		logic [6:0]  note;
		logic        layer;
		logic [1:0]  status;
		logic        stop;
		logic        glide;
		logic [14:0] gpitch;
		logic [31:0] stime;
	} req_item_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        idle_on;
	logic        stall_res;
	logic        pressure_go;
	logic [31:0] now;
	logic [6:0]  center;
	logic [6:0]  held_note[NUM_VOICES];
	logic        held_layer[NUM_VOICES];
	logic        held_rel[NUM_VOICES];
	int          items_sent;
	int          fail_count;
	int          outstanding;
	int          quiet;

	gsvs_req_if req();
	gsvs_res_if res();
	gsvs_cfg_if cfg();

	glide_source_voice_selector_unit #(.NUM_VOICES(NUM_VOICES)) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.res   (res),
		.cfg   (cfg)
	);

	gsvs_source_check #(.NUM_VOICES(NUM_VOICES)) u_source_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.res        (res),
		.cfg        (cfg),
		.fail_count (fail_count),
		.outstanding(outstanding)
	);

	always #10 clk = ~clk;

	function automatic req_item_t rand_req();
		req_item_t it;
		it.func = 3'($urandom);
		it.voice = 4'($urandom);
		it.note = 7'($urandom);
		it.layer = 1'($urandom);
		it.status = 2'($urandom);
		it.stop = 1'($urandom);
		it.glide = 1'($urandom);
		it.gpitch = 15'($urandom);
		it.stime = $urandom;
		return it;
	endfunction

	function automatic logic [6:0] near_note();
		int x;
		if ($urandom_range(9) == 0)
			return 7'($urandom);
		x = int'(center) + int'($urandom_range(30)) - 15;
		if (x < 0)
			x = 0;
		if (x > 127)
			x = 127;
		return 7'(x);
	endfunction

	task automatic put_req(req_item_t it);
		while (idle_on && $urandom_range(99) < 17) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.func <= it.func;
		req.voice_index <= it.voice;
		req.note_number <= it.note;
		req.layer <= it.layer;
		req.voice_status <= it.status;
		req.stop_fading <= it.stop;
		req.gliding <= it.glide;
		req.glide_pitch <= it.gpitch;
		req.sample_time <= it.stime;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
	endtask

	task automatic do_mark(logic rel, logic [3:0] v, logic [6:0] n, logic l);
		req_item_t it;
		it = rand_req();
		it.func = rel ? FUNC_REL : FUNC_HELD;
		it.voice = v;
		it.note = n;
		it.layer = l;
		it.stime = now;
		put_req(it);
		held_note[v] = n;
		held_layer[v] = l;
		held_rel[v] = rel;
		items_sent++;
	endtask

	task automatic do_status(logic [3:0] v, logic [1:0] s, logic sf, logic g, logic [14:0] gp);
		req_item_t it;
		it = rand_req();
		it.func = FUNC_STATUS;
		it.voice = v;
		it.status = s;
		it.stop = sf;
		it.glide = g;
		it.gpitch = gp;
		put_req(it);
		items_sent++;
	endtask

	task automatic do_clear(logic [3:0] v);
		req_item_t it;
		it = rand_req();
		it.func = FUNC_CLEAR;
		it.voice = v;
		put_req(it);
		items_sent++;
	endtask

	task automatic do_query(logic [6:0] n, logic l);
		req_item_t it;
		it = rand_req();
		it.func = FUNC_QUERY;
		it.note = n;
		it.layer = l;
		it.stime = now;
		put_req(it);
		items_sent++;
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [23:0] d);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= d;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
	endtask

	// settings change only once the block has gone quiet
	task automatic set_config(logic e0, logic e1, logic [6:0] r0, logic [6:0] r1,
		logic m0, logic m1, logic [23:0] w0, logic [23:0] w1);
		req.valid <= 1'b0;
		while (outstanding != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		write_reg(CFG_ENABLE_L0, {23'($urandom), e0});
		write_reg(CFG_ENABLE_L1, {23'($urandom), e1});
		write_reg(CFG_RANGE_L0, {17'($urandom), r0});
		write_reg(CFG_RANGE_L1, {17'($urandom), r1});
		write_reg(CFG_MODE_L0, {23'($urandom), m0});
		write_reg(CFG_MODE_L1, {23'($urandom), m1});
		write_reg(CFG_WINDOW_L0, w0);
		write_reg(CFG_WINDOW_L1, w1);
		cfg.valid <= 1'b0;
	endtask

	initial begin
		res.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			res.ready <= !stall_res && (!idle_on || $urandom_range(99) >= 17);
		end
	end

	// long result hold-off while requests keep coming
	initial begin
		stall_res = 1'b0;
		wait (pressure_go);
		stall_res <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		stall_res <= 1'b0;
	end

	initial begin
		quiet = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if ((req.valid && req.ready) || (res.valid && res.ready) || (cfg.valid && cfg.ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("glide_source_voice_selector_unit: mismatch");
				$finish;
			end
		end
	end

	initial begin
		int          base;
		int          kind;
		int          r;
		logic [3:0]  v;
		logic [6:0]  n;
		logic        l;
		logic [23:0] w0;
		logic [23:0] w1;
		req_item_t   it;
		arst_n = 1'b0;
		idle_on = 1'b1;
		pressure_go = 1'b0;
		req.valid = 1'b0;
		req.func = '0;
		req.voice_index = '0;
		req.note_number = '0;
		req.layer = 1'b0;
		req.voice_status = '0;
		req.stop_fading = 1'b0;
		req.gliding = 1'b0;
		req.glide_pitch = '0;
		req.sample_time = '0;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
		now = 32'd1000;
		center = 7'd60;
		items_sent = 0;
		for (int i = 0; i < NUM_VOICES; i++) begin
			held_note[i] = '0;
			held_layer[i] = 1'b0;
			held_rel[i] = 1'b0;
		end
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// search disabled out of reset
		do_query(7'd60, 1'b0);
		set_config(1'b1, 1'b1, 7'd12, 7'd12, 1'b0, 1'b0, 24'd4800, 24'd4800);
		do_mark(1'b0, 4'd0, 7'd60, 1'b0);
		do_status(4'd0, ST_PLAYING, 1'b0, 1'b0, 15'd0);
		do_query(7'd60, 1'b0);
		do_mark(1'b0, 4'd0, 7'd60, 1'b0);
		do_mark(1'b1, 4'd1, 7'd64, 1'b0);
		do_status(4'd1, ST_RELEASING, 1'b0, 1'b0, 15'd0);
		// equal distance, last sample of the window
		now = now + 32'd4800;
		do_query(7'd62, 1'b0);
		now = now + 32'd1;
		do_query(7'd62, 1'b0);
		do_status(4'd2, ST_STEAL, 1'b0, 1'b0, 15'd0);
		do_mark(1'b0, 4'd2, 7'd62, 1'b0);
		do_query(7'd62, 1'b0);
		do_status(4'd3, ST_PLAYING, 1'b0, 1'b1, 15'h7FFF);
		do_mark(1'b0, 4'd3, 7'd127, 1'b1);
		do_query(7'd127, 1'b1);
		do_query(7'd0, 1'b1);
		do_clear(4'd3);
		do_query(7'd127, 1'b1);
		do_status(4'd0, ST_PLAYING, 1'b1, 1'b0, 15'd0);
		do_query(7'd60, 1'b0);
		do_status(4'd4, ST_IDLE, 1'b0, 1'b0, 15'd0);
		do_mark(1'b0, 4'd4, 7'd0, 1'b0);
		do_query(7'd0, 1'b0);
		for (int k = 1; k <= 3; k++) begin
			it = rand_req();
			it.func = FUNC_QUERY + 3'(k);
			put_req(it);
		end

		for (int p = 0; p < PHASE_COUNT; p++) begin
			case (p)
				0: set_config(1'b1, 1'b1, 7'd127, 7'd0, 1'b0, 1'b1, 24'hFFFFFF, 24'd1);
				1: set_config(1'b1, 1'b1, 7'd0, 7'd127, 1'b1, 1'b0, 24'd0, 24'hFFFFFF);
				2: set_config(1'b0, 1'b1, 7'd12, 7'd24, 1'b0, 1'b1, 24'd4800, 24'd64);
				3: set_config(1'b1, 1'b0, 7'd24, 7'd12, 1'b1, 1'b0, 24'd32, 24'd4800);
				default: begin
					w0 = ($urandom_range(3) == 0) ? 24'($urandom) : 24'($urandom_range(1, 8000));
					w1 = ($urandom_range(3) == 0) ? 24'($urandom) : 24'($urandom_range(1, 8000));
					set_config($urandom_range(9) != 0, $urandom_range(9) != 0,
						7'($urandom_range(40)), 7'($urandom), 1'($urandom), 1'($urandom), w0, w1);
				end
			endcase
			if (p == 2)
				pressure_go <= 1'b1;
			if (p == 3)
				idle_on <= 1'b0;
			if (p == 4)
				idle_on <= 1'b1;
			center = 7'($urandom);
			if (p == 5)
				now = 32'hFFFF_F000;
			base = items_sent;
			while (items_sent - base < PHASE_ITEMS) begin
				r = $urandom_range(99);
				if (r < 70)
					now = now + $urandom_range(64);
				else if (r < 95)
					now = now + $urandom_range(6000);
				else
					now = $urandom;
				v = 4'($urandom_range(NUM_VOICES - 1));
				kind = $urandom_range(99);
				if (kind < 35) begin
					// note on: look for a source, then take the voice
					n = near_note();
					l = 1'($urandom);
					do_query(n, l);
					do_mark(1'b0, v, n, l);
					do_status(v, ST_PLAYING, $urandom_range(9) == 0, $urandom_range(2) == 0,
						{near_note(), 8'($urandom)});
				end else if (kind < 55) begin
					do_mark(1'b1, v, held_note[v], held_layer[v]);
					do_status(v, ST_RELEASING, $urandom_range(9) == 0, $urandom_range(2) == 0,
						{near_note(), 8'($urandom)});
				end else if (kind < 62) begin
					do_mark(held_rel[v], v, held_note[v], held_layer[v]);
				end else if (kind < 72) begin
					do_status(v, 2'($urandom), 1'($urandom), 1'($urandom), 15'($urandom));
				end else if (kind < 77) begin
					do_clear(v);
				end else if (kind < 92) begin
					do_query(near_note(), 1'($urandom));
				end else if (kind < 96) begin
					it = rand_req();
					it.func = FUNC_QUERY + 3'($urandom_range(1, 3));
					put_req(it);
				end else begin
					it = rand_req();
					it.func = 3'($urandom_range(int'(FUNC_QUERY)));
					put_req(it);
					items_sent++;
				end
			end
		end

		req.valid <= 1'b0;
		while (outstanding != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("glide_source_voice_selector_unit: match");
		else
			$display("glide_source_voice_selector_unit: mismatch");
		$finish;
	end

endmodule
